// ===== rtl/core/page_slot_replacement_tracker_top_macros.svh =====
// ----------------------------------------------------------------------------
// page_slot_replacement_tracker_top_macros
// Assertion macros shared by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_SLOT_REPLACEMENT_TRACKER_TOP_MACROS_SVH
`define PAGE_SLOT_REPLACEMENT_TRACKER_TOP_MACROS_SVH

// same-cycle implication
`define PSTR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pstr: same-cycle check failed");

// next-cycle implication
`define PSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pstr: next-cycle check failed");

`endif

// ===== rtl/core/pstr_pkg.sv =====
// ----------------------------------------------------------------------------
// pstr_pkg
// Shared types, codes and helper functions of the page slot tracker.
// ----------------------------------------------------------------------------
package pstr_pkg;

    localparam int MAX_SLOTS       = 32;
    localparam int SLOT_CAP        = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
    localparam int SLOT_W          = $clog2(MAX_SLOTS);
    localparam int CNT_W           = SLOT_W + 1;
    localparam int NUM_SLOTS_W     = 6;
    localparam int NUM_SLOTS_RESET = 32;
    localparam int CFG_W           = NUM_SLOTS_W;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [MAX_SLOTS-1:0] mask_t;
    typedef logic [2:0]           mode_t;

    localparam mode_t MODE_REPLACE    = 3'd0;
    localparam mode_t MODE_INSTALL    = 3'd1;
    localparam mode_t MODE_INV_REMOVE = 3'd2;
    localparam mode_t MODE_INV_MARK   = 3'd3;
    localparam mode_t MODE_INV_ALL    = 3'd4;
    localparam mode_t MODE_QUERY      = 3'd5;

    localparam logic CFG_NUM_SLOTS = 1'b0;
    localparam logic CFG_REMOVE    = 1'b1;

    typedef struct packed {
        logic [63:0] volume;
        logic [31:0] page;
        logic [31:0] store;
    } tag_t;

    typedef struct packed {
        mask_t inst;
        mask_t inv;
    } mask_pair_t;

    typedef struct packed {
        logic  done;
        logic  found;
        slot_t dup_slot;
    } scan_status_t;

    function automatic cnt_t slot_limit(logic [NUM_SLOTS_W-1:0] n);
        cnt_t r;
        if (n == '0)
        begin
            r = cnt_t'(1);
        end
        else if (n > NUM_SLOTS_W'(SLOT_CAP))
        begin
            r = cnt_t'(SLOT_CAP);
        end
        else
        begin
            r = cnt_t'(n);
        end
        return r;
    endfunction

    function automatic slot_t lowest_set(mask_t m);
        slot_t r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = slot_t'(i);
            end
        end
        return r;
    endfunction

    function automatic mask_pair_t invalidate(mask_pair_t m, slot_t s, logic remove);
        mask_pair_t r;
        r = m;
        if (m.inst[s])
        begin
            if (remove)
            begin
                r.inst[s] = 1'b0;
                r.inv[s]  = 1'b0;
            end
            else
            begin
                r.inv[s] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pstr_tag_ram.sv =====
// ----------------------------------------------------------------------------
// pstr_tag_ram
// Page identity tag store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pstr_tag_ram (
    input  logic           clk,
    input  logic           we,
    input  pstr_pkg::slot_t waddr,
    input  pstr_pkg::tag_t wdata,
    input  logic           re,
    input  pstr_pkg::slot_t raddr,
    output pstr_pkg::tag_t rdata
);
    import pstr_pkg::*;

    tag_t mem [MAX_SLOTS];
    tag_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pstr_dup_scan.sv =====
// ----------------------------------------------------------------------------
// pstr_dup_scan
// Walks the tag store one slot a cycle through a single identity comparator
// and reports the first other valid slot holding the same page.
// ----------------------------------------------------------------------------
module pstr_dup_scan (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pstr_pkg::slot_t        skip_slot,
    input  pstr_pkg::cnt_t         scan_len,
    input  pstr_pkg::tag_t         ident,
    input  pstr_pkg::mask_t        valid_mask,
    input  pstr_pkg::tag_t         rd_data,
    output logic                   rd_en,
    output pstr_pkg::slot_t        rd_addr,
    output pstr_pkg::scan_status_t status
);
    import pstr_pkg::*;

    logic  busy_reg;
    cnt_t  rd_idx_reg;
    logic  cmp_vld_reg;
    slot_t cmp_idx_reg;
    logic  done_reg;
    logic  found_reg;
    slot_t hit_slot_reg;
    logic  hit;
    logic  finish;

    assign rd_en   = busy_reg && (rd_idx_reg < scan_len);
    assign rd_addr = rd_idx_reg[SLOT_W-1:0];

    assign hit = cmp_vld_reg && (cmp_idx_reg != skip_slot) && valid_mask[cmp_idx_reg]
                 && (rd_data == ident);
    assign finish = busy_reg && (hit || (!cmp_vld_reg && (rd_idx_reg >= scan_len)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            cmp_idx_reg  <= '0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            hit_slot_reg <= '0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            rd_idx_reg   <= '0;
            cmp_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            hit_slot_reg <= '0;
        end
        else
        begin
            done_reg <= finish;
            if (busy_reg)
            begin
                if (finish)
                begin
                    busy_reg <= 1'b0;
                end
                if (hit)
                begin
                    found_reg    <= 1'b1;
                    hit_slot_reg <= cmp_idx_reg;
                end
                cmp_vld_reg <= rd_en;
                cmp_idx_reg <= rd_addr;
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + cnt_t'(1);
                end
            end
        end
    end

    assign status = '{done: done_reg, found: found_reg, dup_slot: hit_slot_reg};

endmodule

// ===== rtl/core/page_slot_replacement_tracker_top.sv =====
// ----------------------------------------------------------------------------
// page_slot_replacement_tracker_top
// Page slot pool tracker: installed/invalid masks, victim choice (lowest invalid
// slot, else round-robin) and duplicate removal on install.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | mode, slot, volume_id, page_number,
//           |                     | store_number
//   out     | out_valid/out_stall | chosen_slot, duplicate_found, duplicate_slot,
//           |                     | slot_installed, slot_valid, no_valid_slot
//   cfg     | cfg_we              | cfg_index, cfg_wdata
//
// Install of a slot below the count: the input is registered, then the tag scan
// reads one tag store entry per cycle into one comparator, then the result is
// registered. Every other mode: the input is registered, then the result is
// registered. Neither takes a new item before its result is loaded. in_stall
// is high from the input transfer until the result is loaded into the output
// register. A stalled result holds the block in its final step; rst_n clears
// both masks, the pointer, the state and out_valid, and loads the configuration
// defaults. Tags need no reset.
// ----------------------------------------------------------------------------
`include "page_slot_replacement_tracker_top_macros.svh"

module page_slot_replacement_tracker_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pstr_pkg::mode_t             mode,
    input  pstr_pkg::slot_t             slot,
    input  logic [63:0]                 volume_id,
    input  logic [31:0]                 page_number,
    input  logic [31:0]                 store_number,
    output logic                        out_valid,
    input  logic                        out_stall,
    output pstr_pkg::slot_t             chosen_slot,
    output logic                        duplicate_found,
    output pstr_pkg::slot_t             duplicate_slot,
    output logic                        slot_installed,
    output logic                        slot_valid,
    output logic                        no_valid_slot,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [pstr_pkg::CFG_W-1:0]  cfg_wdata
);
    import pstr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [NUM_SLOTS_W-1:0] num_slots_reg;
    logic                   remove_reg;
    mask_t                  inst_reg;
    mask_t                  inv_reg;
    slot_t                  ptr_reg;
    slot_t                  ptr_next;
    mask_pair_t             m_next;

    mode_t                  mode_reg;
    slot_t                  slot_reg;
    tag_t                   ident_reg;
    logic                   dup_found_reg;
    slot_t                  dup_slot_reg;

    logic                   out_valid_reg;
    slot_t                  out_chosen_reg;
    logic                   out_dup_found_reg;
    slot_t                  out_dup_slot_reg;
    logic                   out_inst_reg;
    logic                   out_valid_bit_reg;
    logic                   out_none_reg;

    cnt_t                   n_eff;
    mask_t                  lim_mask;
    logic                   in_xfer;
    logic                   out_free;
    logic                   load_out;
    logic                   slot_ok;
    logic                   scan_start;
    slot_t                  chosen;
    mask_t                  cand;
    slot_t                  ptr_inc;
    slot_t                  ptr_wrap;

    logic                   rd_en;
    slot_t                  rd_addr;
    tag_t                   rd_data;
    logic                   ram_we;
    scan_status_t           scan_st;

    assign n_eff = slot_limit(num_slots_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            lim_mask[i] = (cnt_t'(i) < n_eff);
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_out   = (state_reg == S_EXEC) && out_free;
    assign slot_ok    = ({1'b0, slot_reg} < n_eff);
    assign scan_start = in_xfer && (mode == MODE_INSTALL) && ({1'b0, slot} < n_eff);
    assign ram_we     = load_out && (mode_reg == MODE_INSTALL) && slot_ok;

    pstr_tag_ram u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ident_reg),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pstr_dup_scan u_dup_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .skip_slot  (slot_reg),
        .scan_len   (n_eff),
        .ident      (ident_reg),
        .valid_mask (inst_reg & ~inv_reg),
        .rd_data    (rd_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .status     (scan_st)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (scan_start)
                begin
                    state_next = S_SCAN;
                end
                else if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_SCAN:
            begin
                if (scan_st.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cand     = inv_reg & lim_mask;
    assign ptr_inc  = ptr_reg + slot_t'(1);
    assign ptr_wrap = ({1'b0, ptr_inc} >= n_eff) ? '0 : ptr_inc;

    always_comb
    begin
        m_next   = '{inst: inst_reg, inv: inv_reg};
        ptr_next = ptr_reg;
        chosen   = slot_reg;
        case (mode_reg)
            MODE_REPLACE:
            begin
                if (|cand)
                begin
                    chosen = lowest_set(cand);
                end
                else
                begin
                    chosen   = ptr_wrap;
                    ptr_next = ptr_wrap;
                end
                m_next = invalidate(m_next, chosen, remove_reg);
            end
            MODE_INSTALL:
            begin
                if (slot_ok)
                begin
                    if (dup_found_reg)
                    begin
                        m_next = invalidate(m_next, dup_slot_reg, 1'b1);
                    end
                    m_next.inv[slot_reg]  = 1'b0;
                    m_next.inst[slot_reg] = 1'b1;
                end
            end
            MODE_INV_REMOVE, MODE_INV_MARK:
            begin
                if (slot_ok)
                begin
                    m_next = invalidate(m_next, slot_reg, mode_reg == MODE_INV_REMOVE);
                end
            end
            MODE_INV_ALL:
            begin
                m_next.inst = inst_reg & ~lim_mask;
                m_next.inv  = inv_reg & ~lim_mask;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_slots_reg <= NUM_SLOTS_W'(NUM_SLOTS_RESET);
            remove_reg    <= 1'b1;
            inst_reg      <= '0;
            inv_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_SLOTS: num_slots_reg <= cfg_wdata;
                    CFG_REMOVE:    remove_reg    <= cfg_wdata[0];
                    default:       ;
                endcase
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                inst_reg      <= m_next.inst;
                inv_reg       <= m_next.inv;
                ptr_reg       <= ptr_next;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg      <= mode;
            slot_reg      <= slot;
            ident_reg     <= '{volume: volume_id, page: page_number, store: store_number};
            dup_found_reg <= 1'b0;
            dup_slot_reg  <= '0;
        end
        if ((state_reg == S_SCAN) && scan_st.done)
        begin
            dup_found_reg <= scan_st.found;
            dup_slot_reg  <= scan_st.dup_slot;
        end
        if (load_out)
        begin
            out_chosen_reg    <= chosen;
            out_dup_found_reg <= dup_found_reg;
            out_dup_slot_reg  <= dup_slot_reg;
            out_inst_reg      <= m_next.inst[chosen];
            out_valid_bit_reg <= m_next.inst[chosen] && !m_next.inv[chosen];
            out_none_reg      <= ((m_next.inst & ~m_next.inv) == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign chosen_slot     = out_chosen_reg;
    assign duplicate_found = out_dup_found_reg;
    assign duplicate_slot  = out_dup_slot_reg;
    assign slot_installed  = out_inst_reg;
    assign slot_valid      = out_valid_bit_reg;
    assign no_valid_slot   = out_none_reg;

    `PSTR_ASSERT_IMPLY(a_inv_on_installed, clk, rst_n, 1'b1, (inv_reg & ~inst_reg) == '0)
    `PSTR_ASSERT_IMPLY(a_scan_done_in_scan, clk, rst_n, scan_st.done, state_reg == S_SCAN)
    `PSTR_ASSERT_IMPLY(a_dup_not_chosen, clk, rst_n, out_valid_reg && out_dup_found_reg, out_dup_slot_reg != out_chosen_reg)
    `PSTR_ASSERT_IMPLY(a_valid_not_none, clk, rst_n, out_valid_reg && out_valid_bit_reg, !out_none_reg)
    `PSTR_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_reg != S_IDLE)

endmodule
